// ===== rtl/vkh_pkg.sv =====
// Package for the voxel key hash table: sizes, status and register codes.
// No dependencies.
package vkh_pkg;
   localparam int MaxKeys    = 4096;
   localparam int MaxBuckets = 256;
   localparam int KeyW       = $clog2(MaxKeys);
   localparam int LinkW      = KeyW + 1;
   localparam int BucketW    = $clog2(MaxBuckets);

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0, ST_INSERTED = 2'd1, ST_NOT_FOUND = 2'd2, ST_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_DIMENSIONS = 2'd0, REG_BUCKET_COUNT = 2'd1, REG_KEY_LIMIT = 2'd2
   } reg_index_type;

   localparam logic [0:0] REQ_JOIN = 1'b0;

   typedef struct packed {
      logic load;     // capture request, start the hash divide
      logic div_step; // one bit of the remainder
      logic head_rd;  // read the bucket head
      logic ent_rd;   // read entry at current link
      logic follow;   // follow the next link
      logic bump;     // write incremented hit count
      logic insert;   // allocate a new entry
      logic finish;   // load the result register
      status_type st;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic chain_end;
      logic match;
      logic full;
      logic query;
   } stat_type;
endpackage

// ===== rtl/vkh_if.sv =====
// Valid/ready channel interfaces for the voxel key hash table.
// No dependencies.
interface vkh_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] coord_x;
   logic [31:0] coord_y;
   logic [31:0] coord_z;
   modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

interface vkh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] voxel_key;
   logic [31:0] hit_count;
   modport source (output valid, status, voxel_key, hit_count, input ready);
   modport sink (input valid, status, voxel_key, hit_count, output ready);
endinterface

interface vkh_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [12:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/vkh_ctrl.sv =====
// Controller state machine for the voxel key hash table.
// Depends on vkh_pkg.
module vkh_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  vkh_pkg::stat_type stat,
   output vkh_pkg::cmd_type cmd
);
   import vkh_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_HEAD, S_WAIT, S_CHECK, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.st       = ST_FOUND;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_WAIT;
         end
         S_WAIT: begin
            cmd.ent_rd = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (stat.chain_end) begin
               if (stat.query) cmd.st = ST_NOT_FOUND;
               else if (stat.full) cmd.st = ST_FULL;
               else begin
                  cmd.st     = ST_INSERTED;
                  cmd.insert = 1'b1;
               end
               state_in = S_DONE;
            end else if (stat.match) begin
               cmd.st   = ST_FOUND;
               cmd.bump = !stat.query;
               state_in = S_DONE;
            end else begin
               cmd.follow = 1'b1;
               state_in   = S_WAIT;
            end
            if (state_in == S_DONE) cmd.finish = 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== rtl/vkh_datapath.sv =====
// Datapath for the voxel key hash table: registers, serial modulo, memories.
// Depends on vkh_pkg.
module vkh_datapath (
   input  logic                clock,
   input  logic                reset,
   input  vkh_pkg::cmd_type    cmd,
   output vkh_pkg::stat_type   stat,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [12:0]         csr_data,
   input  logic                req_type,
   input  logic [31:0]         coord_x,
   input  logic [31:0]         coord_y,
   input  logic [31:0]         coord_z,
   output logic [1:0]          rsp_status,
   output logic [11:0]         rsp_voxel_key,
   output logic [31:0]         rsp_hit_count
);
   import vkh_pkg::*;

   localparam int DivW = 31;
   localparam int CntW = $clog2(DivW + 1);

   logic [1:0]  dims_ff;
   logic [8:0]  bcount_ff;
   logic [12:0] klimit_ff;

   logic [31:0] x_ff, y_ff, z_ff;
   logic        query_ff;
   logic [30:0] quot_ff;
   logic [BucketW:0] rem_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [BucketW:0] modv_ff;
   logic [LinkW-1:0] cur_ff, kcount_ff;
   logic [LinkW-1:0] head_rd_ff;
   logic [LinkW-1:0] head_mem [MaxBuckets];
   logic [MaxBuckets-1:0] head_vld_ff;
   logic [LinkW-1:0] next_mem [MaxKeys];
   logic [31:0] ex_mem [MaxKeys], ey_mem [MaxKeys], ez_mem [MaxKeys], eh_mem [MaxKeys];
   logic [LinkW-1:0] nx_rd_ff;
   logic [31:0] ex_rd_ff, ey_rd_ff, ez_rd_ff, eh_rd_ff;
   logic        from_head_ff;
   logic [1:0]  st_ff;
   logic [KeyW-1:0] key_ff;
   logic [31:0] hits_ff;

   logic [31:0] sx, sy, sz, sum;
   logic [BucketW:0] modv, rem_sh, bucket_full;
   logic [BucketW-1:0] bucket;
   logic [LinkW-1:0] link, limit;
   logic [KeyW-1:0] idx;
   logic [31:0] hits_inc;

   assign sx  = (dims_ff >= 2'd1) ? coord_x : 32'd0;
   assign sy  = (dims_ff >= 2'd2) ? coord_y : 32'd0;
   assign sz  = (dims_ff == 2'd3) ? coord_z : 32'd0;
   assign sum = sx + sy + sz;

   always_comb begin
      if (bcount_ff == 9'd0) modv = (BucketW+1)'(1);
      else if (bcount_ff > 9'(MaxBuckets)) modv = (BucketW+1)'(MaxBuckets);
      else modv = (BucketW+1)'(bcount_ff);
   end

   assign rem_sh      = {rem_ff[BucketW-1:0], quot_ff[30]};
   assign bucket_full = (rem_sh >= modv_ff) ? rem_sh - modv_ff : rem_sh;
   assign bucket      = rem_ff[BucketW-1:0];
   assign link        = from_head_ff ? head_rd_ff : nx_rd_ff;
   assign idx         = cur_ff[KeyW-1:0];
   assign limit       = (klimit_ff > 13'(MaxKeys)) ? LinkW'(MaxKeys) : LinkW'(klimit_ff);
   assign hits_inc    = (eh_rd_ff == 32'hFFFF_FFFF) ? eh_rd_ff : eh_rd_ff + 32'd1;

   assign stat.div_done  = (cnt_ff == CntW'(DivW - 1));
   assign stat.chain_end = (cur_ff >= kcount_ff);
   assign stat.match     = (ex_rd_ff == x_ff) && (ey_rd_ff == y_ff) && (ez_rd_ff == z_ff);
   assign stat.full      = (kcount_ff >= limit);
   assign stat.query     = query_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff     <= 2'd3;
         bcount_ff   <= 9'd19;
         klimit_ff   <= 13'd4096;
         kcount_ff   <= '0;
         head_vld_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DIMENSIONS:   dims_ff   <= csr_data[1:0];
               REG_BUCKET_COUNT: bcount_ff <= csr_data[8:0];
               REG_KEY_LIMIT:    klimit_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.insert) begin
            kcount_ff           <= kcount_ff + LinkW'(1);
            head_vld_ff[bucket] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= sx;
         y_ff     <= sy;
         z_ff     <= sz;
         query_ff <= (req_type != REQ_JOIN);
         quot_ff  <= sum[30:0];
         rem_ff   <= '0;
         cnt_ff   <= '0;
         modv_ff  <= modv;
      end
      if (cmd.div_step) begin
         rem_ff  <= bucket_full;
         quot_ff <= {quot_ff[29:0], 1'b0};
         cnt_ff  <= cnt_ff + CntW'(1);
      end
      if (cmd.head_rd) begin
         head_rd_ff   <= head_vld_ff[bucket] ? head_mem[bucket] : LinkW'(MaxKeys);
         from_head_ff <= 1'b1;
      end
      if (cmd.ent_rd) begin
         cur_ff   <= link;
         ex_rd_ff <= ex_mem[link[KeyW-1:0]];
         ey_rd_ff <= ey_mem[link[KeyW-1:0]];
         ez_rd_ff <= ez_mem[link[KeyW-1:0]];
         eh_rd_ff <= eh_mem[link[KeyW-1:0]];
         nx_rd_ff <= next_mem[link[KeyW-1:0]];
      end
      if (cmd.follow) from_head_ff <= 1'b0;
      if (cmd.insert) begin
         ex_mem[kcount_ff[KeyW-1:0]]   <= x_ff;
         ey_mem[kcount_ff[KeyW-1:0]]   <= y_ff;
         ez_mem[kcount_ff[KeyW-1:0]]   <= z_ff;
         eh_mem[kcount_ff[KeyW-1:0]]   <= 32'd1;
         next_mem[kcount_ff[KeyW-1:0]] <= head_rd_ff;
         head_mem[bucket]              <= kcount_ff;
      end
      if (cmd.bump) eh_mem[idx] <= hits_inc;
      if (cmd.finish) begin
         st_ff <= cmd.st;
         case (cmd.st)
            ST_FOUND: begin
               key_ff  <= idx;
               hits_ff <= query_ff ? eh_rd_ff : hits_inc;
            end
            ST_INSERTED: begin
               key_ff  <= kcount_ff[KeyW-1:0];
               hits_ff <= 32'd1;
            end
            default: begin
               key_ff  <= '0;
               hits_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_status    = st_ff;
   assign rsp_voxel_key = key_ff;
   assign rsp_hit_count = hits_ff;
endmodule

// ===== rtl/voxel_key_hash_table_top.sv =====
// Top level of the voxel key hash table: controller plus datapath.
// Depends on vkh_pkg, vkh_if, vkh_ctrl and vkh_datapath.
//
// Each request is accepted in S_IDLE, then a 31-bit bit-serial modulo gives the
// bucket (S_DIV), the bucket head is read (S_HEAD), and each link checked takes an
// entry read (S_WAIT) and a compare (S_CHECK) (each chain entry compared, plus the
// end of the chain on a miss); S_DONE then hands off the response and holds while
// the output stalls. The single-port entry memories set the walk rate. One
// request is worked at a time; configuration writes are always accepted.
module voxel_key_hash_table_top (
   input logic     clock,
   input logic     reset,
   vkh_req_if.sink req,
   vkh_rsp_if.source rsp,
   vkh_csr_if.sink csr
);
   import vkh_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr.ready = 1'b1;

   vkh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vkh_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr.valid),
      .csr_index     (csr.index),
      .csr_data      (csr.data),
      .req_type      (req.req_type),
      .coord_x       (req.coord_x),
      .coord_y       (req.coord_y),
      .coord_z       (req.coord_z),
      .rsp_status    (rsp.status),
      .rsp_voxel_key (rsp.voxel_key),
      .rsp_hit_count (rsp.hit_count)
   );
endmodule

// ===== verif/voxel_key_hash_table_top_tb.sv =====
// Self-checking testbench for voxel_key_hash_table_top: random and directed join and query
// requests, predicted by a local chained hash table and checked in order.
// Depends on vkh_pkg, the vkh_if interfaces and the RTL of the block.
module voxel_key_hash_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vkh_pkg::*;

   typedef struct {
      logic        query;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } voxel_req_t;

   typedef struct {
      status_type  st;
      logic [11:0] key;
      logic [31:0] hits;
   } voxel_rsp_t;

   localparam int CycleLimit = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vkh_req_if req ();
   vkh_rsp_if rsp ();
   vkh_csr_if csr ();

   voxel_key_hash_table_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   voxel_req_t  pending_reqs[$];
   voxel_rsp_t  expected_rsps[$];
   voxel_req_t  recent_joins[$];

   logic [1:0]         cfg_dims = 2'd3;
   logic [8:0]         cfg_buckets = 9'd19;
   logic [12:0]        cfg_limit = 13'd4096;
   logic [LinkW-1:0]   key_count = '0;
   logic [LinkW-1:0]   chain_head[MaxBuckets];
   logic [LinkW-1:0]   chain_next[MaxKeys];
   logic [31:0]        ent_x[MaxKeys];
   logic [31:0]        ent_y[MaxKeys];
   logic [31:0]        ent_z[MaxKeys];
   logic [31:0]        ent_hits[MaxKeys];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_seq = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  errors = 0;
   int  cycles = 0;
   logic req_fire = 1'b0;

   initial begin
      for (int i = 0; i < MaxBuckets; i++) chain_head[i] = LinkW'(MaxKeys);
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hash lookup with join or query semantics; updates the local table.
   task automatic hash_join_lookup(input voxel_req_t r, output voxel_rsp_t res);
      logic [31:0]      x, y, z, m, bkt, steps, limit;
      logic [LinkW-1:0] e;
      x = cfg_dims >= 1 ? r.x : 32'd0;
      y = cfg_dims >= 2 ? r.y : 32'd0;
      z = cfg_dims >= 3 ? r.z : 32'd0;
      m = cfg_buckets;
      if (m == 0) m = 1;
      if (m > MaxBuckets) m = MaxBuckets;
      bkt = ((x + y + z) & 32'h7fffffff) % m;
      limit = cfg_limit > MaxKeys ? MaxKeys : cfg_limit;
      e = chain_head[bkt];
      steps = 0;
      while (e < key_count && steps <= key_count) begin
         if (ent_x[e] == x && ent_y[e] == y && ent_z[e] == z) break;
         e = chain_next[e];
         steps++;
      end
      if (!(e < key_count && steps <= key_count)) e = LinkW'(MaxKeys);
      res.key = '0;
      res.hits = '0;
      if (e != LinkW'(MaxKeys)) begin
         if (r.query == REQ_JOIN && ent_hits[e] != 32'hffffffff) ent_hits[e]++;
         res.st = ST_FOUND;
         res.key = e[11:0];
         res.hits = ent_hits[e];
      end else if (r.query != REQ_JOIN) begin
         res.st = ST_NOT_FOUND;
      end else if (key_count >= limit) begin
         res.st = ST_FULL;
      end else begin
         e = key_count;
         ent_x[e] = x;
         ent_y[e] = y;
         ent_z[e] = z;
         ent_hits[e] = 1;
         chain_next[e] = chain_head[bkt];
         chain_head[bkt] = e;
         key_count++;
         res.st = ST_INSERTED;
         res.key = e[11:0];
         res.hits = 1;
      end
   endtask

   always @(posedge clock) begin
      voxel_rsp_t want;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("voxel_key_hash_table_top_tb NOT OK");
         $finish;
      end
      req_fire <= !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready) begin
            hash_join_lookup('{req.req_type, req.coord_x, req.coord_y, req.coord_z}, want);
            expected_rsps.push_back(want);
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_DIMENSIONS: cfg_dims = csr.data[1:0];
               REG_BUCKET_COUNT: cfg_buckets = csr.data[8:0];
               REG_KEY_LIMIT: cfg_limit = csr.data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected response status %0d key %0d hits %0d", $time,
                        rsp.status, rsp.voxel_key, rsp.hit_count);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp.status !== want.st || rsp.voxel_key !== want.key ||
                   rsp.hit_count !== want.hits) begin
                  errors++;
                  $display("%0t: expected status %0d key %0d hits %0d, got %0d %0d %0d",
                           $time, want.st, want.key, want.hits,
                           rsp.status, rsp.voxel_key, rsp.hit_count);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      voxel_req_t r;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_fire) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            r = pending_reqs.pop_front();
            req.valid <= 1'b1;
            req.req_type <= r.query;
            req.coord_x <= r.x;
            req.coord_y <= r.y;
            req.coord_z <= r.z;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= 400;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(8)) - 4);
         default: return $urandom_range(20);
      endcase
   endfunction

   function automatic voxel_req_t random_request();
      voxel_req_t r;
      r.query = ($urandom_range(99) < 30);
      if (recent_joins.size() > 0 && $urandom_range(99) < 55) begin
         r = recent_joins[$urandom_range(recent_joins.size() - 1)];
         r.query = ($urandom_range(99) < 40);
      end else begin
         r.x = pick_coord();
         r.y = pick_coord();
         r.z = pick_coord();
      end
      if (!r.query) begin
         recent_joins.push_back(r);
         if (recent_joins.size() > 64) void'(recent_joins.pop_front());
      end
      return r;
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [12:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_phase(input logic [12:0] dims, input logic [12:0] buckets,
                            input logic [12:0] limit, input int send, input int stall,
                            input int count, input bit hold);
      write_reg(REG_DIMENSIONS, dims);
      write_reg(REG_BUCKET_COUNT, buckets);
      write_reg(REG_KEY_LIMIT, limit);
      send_idle_pct = send;
      stall_pct = stall;
      for (int i = 0; i < count; i++) pending_reqs.push_back(random_request());
      if (hold) begin
         repeat (200) @(posedge clock);
         hold_seq++;
      end
      wait_drained();
   endtask

   initial begin
      req.valid = 1'b0;
      req.req_type = 1'b0;
      req.coord_x = '0;
      req.coord_y = '0;
      req.coord_z = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = REG_DIMENSIONS;
      csr.data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extremes, wrapped sums, repeated joins, query hits and misses.
      pending_reqs.push_back('{1'b1, 32'd0, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b0, 32'd0, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b0, 32'd0, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b1, 32'd0, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff});
      pending_reqs.push_back('{1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
      pending_reqs.push_back('{1'b0, 32'h80000000, 32'h80000000, 32'h80000000});
      pending_reqs.push_back('{1'b0, 32'h7fffffff, 32'd1, 32'd0});
      pending_reqs.push_back('{1'b0, 32'd1, 32'h7fffffff, 32'd0});
      pending_reqs.push_back('{1'b0, 32'd0, 32'd1, 32'h7fffffff});
      pending_reqs.push_back('{1'b0, 32'd19, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b0, 32'd38, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b1, 32'd57, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
      pending_reqs.push_back('{1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff});
      pending_reqs.push_back('{1'b0, 32'h80000000, 32'h80000000, 32'h80000000});
      pending_reqs.push_back('{1'b1, 32'h80000000, 32'h80000000, 32'h7fffffff});
      pending_reqs.push_back('{1'b0, 32'd38, 32'd0, 32'd0});
      pending_reqs.push_back('{1'b1, 32'd19, 32'd0, 32'd0});
      wait_drained();

      run_phase(13'd3, 13'd19, 13'd4096, 53, 0, 300, 1'b0);
      run_phase(13'd2, 13'd256, 13'd8191, 0, 53, 300, 1'b1);
      run_phase(13'd1, 13'd511, 13'd4096, 30, 30, 250, 1'b0);
      run_phase(13'd0, 13'd0, 13'd4096, 0, 0, 30, 1'b0);
      run_phase(13'd3, 13'd97, 13'(key_count + 40), 30, 30, 250, 1'b0);
      run_phase(13'd3, 13'd256, 13'd0, 0, 0, 60, 1'b0);
      run_phase(13'd3, 13'd19, 13'd4096, 53, 0, 200, 1'b0);

      if (errors == 0) begin
         $display("voxel_key_hash_table_top_tb OK");
      end else begin
         $display("voxel_key_hash_table_top_tb NOT OK");
      end
      $finish;
   end
endmodule
